FILE: rtl/gra_pkg.sv
// Shared types and constants for the plane-rotation datapath
package gra_pkg;
  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam int unsigned CFG_COSINE = 0;
  localparam int unsigned CFG_SINE = 1;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;
    logic [47:0] mant;
  } prod_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [10:0] exp;
    logic [27:0] mant;
  } sum_t;
endpackage

FILE: rtl/gra_mul.sv
// Single-precision multiplier: raw product stage, then round stage
module gra_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  import gra_pkg::*;

  prod_t       r;
  prod_t       r_next;
  logic [31:0] p_next;

  always_comb begin
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        na;
    logic        nb;
    logic        ia;
    logic        ib;
    logic        za;
    logic        zb;
    ea = a[30:23];
    eb = b[30:23];
    ma = {(ea != 8'd0), a[22:0]};
    mb = {(eb != 8'd0), b[22:0]};
    na = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nb = (eb == 8'hFF) && (b[22:0] != 23'd0);
    ia = (ea == 8'hFF) && (a[22:0] == 23'd0);
    ib = (eb == 8'hFF) && (b[22:0] == 23'd0);
    za = (a[30:0] == 31'd0);
    zb = (b[30:0] == 31'd0);
    r_next.sign = a[31] ^ b[31];
    r_next.nan  = na || nb || (ia && zb) || (ib && za);
    r_next.inf  = ia || ib;
    r_next.zero = za || zb;
    r_next.exp  = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd127;
    r_next.mant = ma * mb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= r_next;
      p <= p_next;
    end
  end

  always_comb begin
    logic [5:0]  lz;
    logic [47:0] m;
    logic signed [11:0] e;
    logic [49:0] w;
    logic [24:0] q;
    logic        g;
    logic        st;
    logic [5:0]  sh;
    lz = 6'd0;
    sh = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (r.mant[i]) lz = 6'(47 - i);
    end
    // value = mant * 2^(exp-127-46); normalise so bit 47 is leading
    e = {r.exp[10], r.exp} + 12'sd1 - $signed({6'd0, lz});
    m = r.mant << lz;
    if (e < 12'sd1) begin
      sh = (e < -12'sd30) ? 6'd31 : 6'(12'sd1 - e);
      w  = {m, 2'b0} >> sh;
      st = ((({m, 2'b0}) & ~({50{1'b1}} << sh)) != 50'd0);
      e  = 12'sd0;
    end else begin
      w  = {m, 2'b0};
      st = 1'b0;
    end
    q  = {1'b0, w[49:26]};
    g  = w[25];
    st = st || (w[24:0] != 25'd0);
    if (g && (st || q[0])) q = q + 25'd1;
    if (q[24]) begin
      q = q >> 1;
      e = e + 12'sd1;
    end else if (e == 12'sd0 && q[23]) begin
      e = 12'sd1;
    end
    if (r.nan) p_next = QNAN;
    else if (r.inf) p_next = {r.sign, 8'hFF, 23'd0};
    else if (r.zero) p_next = {r.sign, 31'd0};
    else if (e >= 12'sd255) p_next = {r.sign, 8'hFF, 23'd0};
    else p_next = {r.sign, e[7:0], q[22:0]};
  end
endmodule

FILE: rtl/gra_add.sv
// Single-precision adder: align stage, then normalise and round stage
module gra_add (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  import gra_pkg::*;

  sum_t        r;
  sum_t        r_next;
  logic [31:0] s_next;

  always_comb begin
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  el;
    logic [7:0]  es;
    logic [26:0] ml;
    logic [26:0] ms;
    logic [26:0] mt;
    logic        sl;
    logic        sm;
    logic [7:0]  d;
    logic        stk;
    logic        ia;
    logic        ib;
    ea = a[30:23];
    eb = b[30:23];
    ia = (ea == 8'hFF) && (a[22:0] == 23'd0);
    ib = (eb == 8'hFF) && (b[22:0] == 23'd0);
    r_next.nan = ((ea == 8'hFF) && (a[22:0] != 23'd0)) ||
                 ((eb == 8'hFF) && (b[22:0] != 23'd0)) ||
                 (ia && ib && (a[31] != b[31]));
    r_next.inf = ia || ib;
    if (a[30:0] >= b[30:0]) begin
      el = ea; es = eb; sl = a[31]; sm = b[31];
      ml = {(ea != 8'd0), a[22:0], 3'b0};
      ms = {(eb != 8'd0), b[22:0], 3'b0};
    end else begin
      el = eb; es = ea; sl = b[31]; sm = a[31];
      ml = {(eb != 8'd0), b[22:0], 3'b0};
      ms = {(ea != 8'd0), a[22:0], 3'b0};
    end
    d = ((el == 8'd0) ? 8'd1 : el) - ((es == 8'd0) ? 8'd1 : es);
    if (d > 8'd26) begin
      mt  = 27'd0;
      stk = (ms != 27'd0);
    end else begin
      mt  = ms >> d;
      stk = ((ms & ~({27{1'b1}} << d)) != 27'd0);
    end
    mt[0] = mt[0] | stk;
    r_next.sign = ia ? a[31] : (ib ? b[31] : sl);
    if (sl == sm) r_next.mant = {1'b0, ml} + {1'b0, mt};
    else r_next.mant = {1'b0, ml} - {1'b0, mt};
    r_next.zero = (r_next.mant == 28'd0);
    if (r_next.zero) r_next.sign = (sl == sm) ? sl : 1'b0;
    r_next.exp = $signed({3'd0, (el == 8'd0) ? 8'd1 : el});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= r_next;
      s <= s_next;
    end
  end

  always_comb begin
    logic [4:0]  lz;
    logic [27:0] m;
    logic signed [11:0] e;
    logic [24:0] q;
    logic        g;
    logic        st;
    lz = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (r.mant[i]) lz = 5'(27 - i);
    end
    // mant bit 26 carries weight of exponent exp; bit 27 is carry
    e = {r.exp[10], r.exp} + 12'sd1 - $signed({7'd0, lz});
    if (e < 12'sd1) begin
      m = r.mant << 5'(12'({r.exp[10], r.exp}));
      e = 12'sd0;
    end else begin
      m = r.mant << lz;
    end
    q  = {1'b0, m[27:4]};
    g  = m[3];
    st = (m[2:0] != 3'd0);
    if (g && (st || q[0])) q = q + 25'd1;
    if (q[24]) begin
      q = q >> 1;
      e = e + 12'sd1;
    end else if (e == 12'sd0 && q[23]) begin
      e = 12'sd1;
    end
    if (r.nan) s_next = QNAN;
    else if (r.inf) s_next = {r.sign, 8'hFF, 23'd0};
    else if (r.zero) s_next = {r.sign, 31'd0};
    else if (e >= 12'sd255) s_next = {r.sign, 8'hFF, 23'd0};
    else s_next = {r.sign, e[7:0], q[22:0]};
  end
endmodule

FILE: rtl/givens_rotation_apply.sv
// Top level: Givens rotation of a stream of single-precision pairs
// Takes one (x, y) pair per clock unless stalled and returns (c*x + s*y,
// c*y - s*x) through two multiplier stages then two adder stages, all
// enabled together with the valid bits, so a stall at the output holds
// every stage and a skid-free pipeline accepts a new word each cycle the
// output moves. Products and sums are rounded to nearest even, subnormals
// are kept and every NaN comes out as 0x7FC00000. c resets to 1.0 and s
// to 0.0; write them only while the pipeline is empty.
module givens_rotation_apply (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // x_bits[31:0], y_bits[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // new_x_bits[31:0], new_y_bits[63:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import gra_pkg::*;

  logic [31:0] cosine_bits;
  logic [31:0] sine_bits;
  logic [3:0]  vld;
  logic        en;
  logic [31:0] cx;
  logic [31:0] sy;
  logic [31:0] cy;
  logic [31:0] sx;

  assign en = m_tready || !vld[3];
  assign s_tready = en;
  assign m_tvalid = vld[3];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      cosine_bits <= 32'h3F800000;
      sine_bits <= 32'h0;
    end else begin
      if (en) vld <= {vld[2:0], s_tvalid};
      if (cfg_valid) begin
        if (cfg_index == 1'(CFG_COSINE)) cosine_bits <= cfg_data;
        else sine_bits <= cfg_data;
      end
    end
  end

  gra_mul u_cx (.clk(clk), .en(en), .a(cosine_bits), .b(s_tdata[31:0]), .p(cx));
  gra_mul u_sy (.clk(clk), .en(en), .a(sine_bits), .b(s_tdata[63:32]), .p(sy));
  gra_mul u_cy (.clk(clk), .en(en), .a(cosine_bits), .b(s_tdata[63:32]), .p(cy));
  gra_mul u_sx (.clk(clk), .en(en), .a(sine_bits), .b(s_tdata[31:0]), .p(sx));

  gra_add u_nx (.clk(clk), .en(en), .a(cx), .b(sy), .s(m_tdata[31:0]));
  gra_add u_ny (.clk(clk), .en(en), .a(cy), .b({~sx[31], sx[30:0]}),
                .s(m_tdata[63:32]));
endmodule
